// ----- rtl/tfrb_pkg.sv -----
`timescale 1ns / 1ps

package tfrb_pkg;

    localparam int STATE_W       = 32;
    localparam int OUT_W         = 64;
    localparam int CNT_W         = 6;
    localparam int FRACTION_BITS = 53;
    localparam int MAX_BITS      = 32;
    localparam int MANT_W        = 52;
    localparam int EXP_W         = 11;
    localparam int EXP_BIAS      = 1023;

    localparam logic [STATE_W-1:0] STEP_OR_MASK = 32'h0000_0005;

    localparam logic CMD_GET_BITS   = 1'b0;
    localparam logic CMD_GET_DOUBLE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic start;      // clear accumulator, latch mode
        logic is_double;  // mode for start
        logic step;       // advance generator one bit
        logic load_out;   // capture result into output register
    } ctrl_cmd_t;

endpackage

// ----- rtl/t_function_random_bits.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------
// in       | request   | in_valid / in_stall   | command[0:0], bit_count[5:0]
// out      | result    | out_valid / out_stall | value[63:0]
// seed     | config    | seed_we               | seed[31:0]
//
// Steps: get bits draws N bits (N = bit_count, saturated to 32), get double draws 53;
//   one generator step (32x32 square + add) per cycle, then the result is loaded.
// A zero count for get bits skips stepping and returns 0.
// Reset (rst_n, async low) clears the generator state to 0 and empties the output.
// The output register frees the engine: a new request is taken while a result
//   waits; the engine only holds in its finish state if the old result is unread.

module t_function_random_bits (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [5:0]  bit_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value
);

    tfrb_pkg::ctrl_cmd_t cmd;

    // sequencer: request accept, step count, result hand-off
    tfrb_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // generator state, bit accumulator, double packing, output register
    tfrb_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed_we (seed_we),
        .seed    (seed),
        .cmd     (cmd),
        .value   (value)
    );

    // accepted request makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("not busy after request accept");

    // a result load always raises out_valid
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result loaded but out_valid low");

    // new result only appears through a load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("out_valid rose without load");

    // commands are mutually exclusive
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.step, cmd.load_out}))
        else $error("overlapping datapath commands");

endmodule

// ----- rtl/tfrb_datapath.sv -----
`timescale 1ns / 1ps

module tfrb_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          seed_we,
    input  logic [tfrb_pkg::STATE_W-1:0]  seed,
    input  tfrb_pkg::ctrl_cmd_t           cmd,
    output logic [tfrb_pkg::OUT_W-1:0]    value
);

    logic [tfrb_pkg::STATE_W-1:0]       state_reg, state_next;
    logic [tfrb_pkg::STATE_W-1:0]       square;
    logic [tfrb_pkg::FRACTION_BITS-1:0] acc_reg, acc_next;
    logic                               mode_reg, mode_next;
    logic [tfrb_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic [tfrb_pkg::CNT_W-1:0]         top_reg, top_next;
    logic                               any_reg, any_next;
    logic [tfrb_pkg::OUT_W-1:0]         value_reg, value_next;
    logic                               new_bit;
    logic [tfrb_pkg::CNT_W-1:0]         norm_shift;
    logic [tfrb_pkg::FRACTION_BITS-1:0] norm;
    logic [tfrb_pkg::EXP_W-1:0]         biased;

    // one T-function step: s + (s*s | 5), low 32 bits
    assign square     = tfrb_pkg::STATE_W'(state_reg * state_reg);
    assign state_next = seed_we  ? seed :
                        cmd.step ? state_reg + (square | tfrb_pkg::STEP_OR_MASK) :
                                   state_reg;
    assign new_bit    = state_next[tfrb_pkg::STATE_W-1];

    always_comb
    begin
        acc_next  = acc_reg;
        mode_next = mode_reg;
        idx_next  = idx_reg;
        top_next  = top_reg;
        any_next  = any_reg;
        if (cmd.start)
        begin
            acc_next  = '0;
            mode_next = cmd.is_double;
            idx_next  = '0;
            top_next  = '0;
            any_next  = 1'b0;
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg + 1'b1;
            if (mode_reg == tfrb_pkg::CMD_GET_DOUBLE)
            begin
                // first bit ends up least significant
                acc_next = {new_bit, acc_reg[tfrb_pkg::FRACTION_BITS-1:1]};
                if (new_bit)
                begin
                    top_next = idx_reg;
                    any_next = 1'b1;
                end
            end
            else
            begin
                acc_next = {acc_reg[tfrb_pkg::FRACTION_BITS-2:0], new_bit};
            end
        end
    end

    // top bit position is tracked while bits arrive, so packing is one shift
    assign norm_shift = tfrb_pkg::CNT_W'(tfrb_pkg::FRACTION_BITS - 1) - top_reg;
    assign norm       = acc_reg << norm_shift;
    assign biased     = tfrb_pkg::EXP_W'(tfrb_pkg::EXP_BIAS - tfrb_pkg::FRACTION_BITS)
                      + tfrb_pkg::EXP_W'(top_reg);

    always_comb
    begin
        value_next = value_reg;
        if (cmd.load_out)
        begin
            if (mode_reg == tfrb_pkg::CMD_GET_DOUBLE)
                value_next = any_reg ? {1'b0, biased, norm[tfrb_pkg::MANT_W-1:0]} : '0;
            else
                value_next = {{(tfrb_pkg::OUT_W-tfrb_pkg::MAX_BITS){1'b0}},
                              acc_reg[tfrb_pkg::MAX_BITS-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mode_reg  <= mode_next;
        idx_reg   <= idx_next;
        top_reg   <= top_next;
        any_reg   <= any_next;
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/tfrb_controller.sv -----
`timescale 1ns / 1ps

module tfrb_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [tfrb_pkg::CNT_W-1:0]  bit_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output tfrb_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [tfrb_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tfrb_pkg::CNT_W-1:0] req_steps;
    logic                       accept;
    logic                       out_free;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (command == tfrb_pkg::CMD_GET_DOUBLE)
            req_steps = tfrb_pkg::CNT_W'(tfrb_pkg::FRACTION_BITS);
        else if (bit_count > tfrb_pkg::CNT_W'(tfrb_pkg::MAX_BITS))
            req_steps = tfrb_pkg::CNT_W'(tfrb_pkg::MAX_BITS);
        else
            req_steps = bit_count;
    end

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.is_double  = (command == tfrb_pkg::CMD_GET_DOUBLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    rem_next   = req_steps;
                    state_next = (req_steps == '0) ? S_FINISH : S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == tfrb_pkg::CNT_W'(1))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- bench/tfrb_checker.sv -----
`timescale 1ns / 1ps

module tfrb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [5:0]  bit_count,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] value,
    output int          mismatch_count,
    output int          results_owed
);

    logic [tfrb_pkg::STATE_W-1:0] gen_state;
    logic [tfrb_pkg::OUT_W-1:0]   value_due_q[$];

    function automatic logic [tfrb_pkg::STATE_W-1:0] tfn_next(
        input logic [tfrb_pkg::STATE_W-1:0] s);
        logic [tfrb_pkg::STATE_W-1:0] sq;
        sq = s * s;
        return s + (sq | tfrb_pkg::STEP_OR_MASK);
    endfunction

    // m / 2^53 as a binary64 pattern; m is always below 2^53
    function automatic logic [tfrb_pkg::OUT_W-1:0] fraction_to_double(
        input logic [tfrb_pkg::FRACTION_BITS-1:0] m);
        int                         msb;
        logic [tfrb_pkg::OUT_W-1:0] mant;
        logic [tfrb_pkg::EXP_W-1:0] expo;
        if (m == '0)
            return '0;
        msb = 0;
        for (int p = 0; p < tfrb_pkg::FRACTION_BITS; p++)
            if (m[p])
                msb = p;
        mant = {{(tfrb_pkg::OUT_W-tfrb_pkg::FRACTION_BITS){1'b0}}, m}
               << (tfrb_pkg::MANT_W - msb);
        expo = tfrb_pkg::EXP_W'(tfrb_pkg::EXP_BIAS + msb - tfrb_pkg::FRACTION_BITS);
        return {1'b0, expo, mant[tfrb_pkg::MANT_W-1:0]};
    endfunction

    task automatic draw_from_generator(input logic cmd,
                                       input logic [tfrb_pkg::CNT_W-1:0] cnt,
                                       output logic [tfrb_pkg::OUT_W-1:0] res);
        logic [tfrb_pkg::STATE_W-1:0]       acc;
        logic [tfrb_pkg::FRACTION_BITS-1:0] frac;
        int                                 n;
        acc  = '0;
        frac = '0;
        if (cmd == tfrb_pkg::CMD_GET_BITS) begin
            n = (cnt > tfrb_pkg::MAX_BITS) ? tfrb_pkg::MAX_BITS : int'(cnt);
            for (int i = 0; i < n; i++) begin
                gen_state = tfn_next(gen_state);
                acc = {acc[tfrb_pkg::STATE_W-2:0], gen_state[tfrb_pkg::STATE_W-1]};
            end
            res = {{(tfrb_pkg::OUT_W-tfrb_pkg::STATE_W){1'b0}}, acc};
        end else begin
            // first bit lands in the LSB
            for (int i = 0; i < tfrb_pkg::FRACTION_BITS; i++) begin
                gen_state = tfn_next(gen_state);
                frac[i] = gen_state[tfrb_pkg::STATE_W-1];
            end
            res = fraction_to_double(frac);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic [tfrb_pkg::OUT_W-1:0] predicted;
        logic [tfrb_pkg::OUT_W-1:0] due;
        if (!rst_n) begin
            gen_state = '0;
            value_due_q.delete();
            mismatch_count = 0;
            results_owed <= 0;
        end else begin
            if (seed_we)
                gen_state = seed;
            if (in_valid && !in_stall) begin
                draw_from_generator(command, bit_count, predicted);
                value_due_q.push_back(predicted);
            end
            if (out_valid && !out_stall) begin
                if (value_due_q.size() == 0) begin
                    $error("value: no request outstanding, got %h", value);
                    mismatch_count++;
                end else begin
                    due = value_due_q.pop_front();
                    if (value !== due) begin
                        $error("value: expected %h, got %h", due, value);
                        mismatch_count++;
                    end
                end
            end
            results_owed <= value_due_q.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seed_we = 1'b0;
    logic [31:0] seed = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = tfrb_pkg::CMD_GET_BITS;
    logic [5:0]  bit_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] value;

    int mismatch_count;
    int results_owed;

    // per-cycle idle odds in percent for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_function_random_bits u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed      (seed),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    tfrb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed_we        (seed_we),
        .seed           (seed),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .bit_count      (bit_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Result side: stall drawn fresh each cycle, independent of out_valid.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // One request: optional idle cycles, then hold until the block takes it.
    // valid stays high into the next request when no gap is drawn.
    task automatic send_request(input logic cmd, input logic [5:0] cnt);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        bit_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait for every owed result. Each request yields a result,
    // so once the count hits zero the engine is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Seed write loads the generator at once; only called with the block idle.
    task automatic write_seed(input logic [31:0] v);
        seed_we <= 1'b1;
        seed    <= v;
        @(posedge clk);
        seed_we <= 1'b0;
    endtask

    // Mostly counts in the legal range, a quarter over the whole 6-bit field
    // so that saturation above 32 gets hit often. About 30 percent are doubles.
    task automatic send_random_request();
        logic       cmd;
        logic [5:0] cnt;
        cmd = ($urandom_range(0, 99) < 30) ? tfrb_pkg::CMD_GET_DOUBLE
                                           : tfrb_pkg::CMD_GET_BITS;
        if ($urandom_range(0, 3) == 0)
            cnt = 6'($urandom_range(0, 63));
        else
            cnt = 6'($urandom_range(0, 32));
        send_request(cmd, cnt);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. Starts from the reset state of zero.
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd0);     // zero count: result 0, state kept
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd1);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd0);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd32);    // full width
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd33);    // saturates to 32
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd63);    // all count bits set, saturates
        send_request(tfrb_pkg::CMD_GET_DOUBLE, 6'd0);
        send_request(tfrb_pkg::CMD_GET_DOUBLE, 6'd63);  // count ignored for doubles
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd31);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd16);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd2);
        send_request(tfrb_pkg::CMD_GET_DOUBLE, 6'd32);
        drain_results();

        // Seed extremes. A zero fraction needs 53 clear top bits in a row and
        // cannot be steered to, so doubles just run from several starting points.
        write_seed(32'hFFFF_FFFF);
        send_request(tfrb_pkg::CMD_GET_DOUBLE, 6'd0);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd32);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd0);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd1);
        drain_results();
        write_seed(32'h8000_0000);
        send_request(tfrb_pkg::CMD_GET_DOUBLE, 6'd0);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd40);
        drain_results();
        write_seed(32'h0000_0000);
        send_request(tfrb_pkg::CMD_GET_DOUBLE, 6'd0);
        send_request(tfrb_pkg::CMD_GET_BITS, 6'd32);

        // Random part in three idling phases: receiver-heavy stalls, then
        // sender-heavy gaps, then full rate. A fresh seed every 150 requests.
        for (int phase = 0; phase < 3; phase++)
        begin
            drain_results();
            unique case (phase)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_seed($urandom);
            for (int i = 0; i < 530; i++)
            begin
                if (i % 150 == 149)
                begin
                    drain_results();
                    write_seed($urandom);
                end
                send_random_request();
            end
        end

        drain_results();
        // nothing owed; give a late stray result time to show up
        repeat (60) @(posedge clk);

        if (mismatch_count == 0)
            $display("t_function_random_bits verification clean");
        else
            $display("t_function_random_bits verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (all doubles at full stall odds).
    initial
    begin
        #10_000_000;
        $display("t_function_random_bits verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tfrb_pkg.sv
rtl/tfrb_datapath.sv
rtl/tfrb_controller.sv
rtl/t_function_random_bits.sv
bench/tfrb_checker.sv
bench/tb_top.sv
